/* hw/rtl/dpes_pkg.sv */
package dpes_pkg;

  // hash multipliers for the low and high endpoint
  localparam int unsigned HASH_MUL_LO = 10009;
  localparam int unsigned HASH_MUL_HI = 1009;

  // operation codes (s_tuser)
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_SWAP = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // status codes (m_tuser)
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_APPLIED  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  // index update jobs run by the sequencer
  typedef enum logic [2:0] {
    JOB_CON_1 = 3'd0,
    JOB_CON_2 = 3'd1,
    JOB_UNL_K = 3'd2,
    JOB_UNL_L = 3'd3,
    JOB_LNK_K = 3'd4,
    JOB_LNK_L = 3'd5
  } job_t;

endpackage

/* hw/rtl/degree_preserving_edge_swap_core.sv */
// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | tuser: operation; tdata: first_index, second_index,
//         |     |                  |        node_a, node_b
// m       | out | m_tvalid/tready  | tuser: status; tdata: edge_low, edge_high
// cfg     | in  | cfg_valid/ready  | cfg_data: edge_count
//
// one item at a time; a read or a range fault runs no index job, a load 1 or 2 index jobs,
// a swap up to 6 jobs. each job hashes its edge (the hash modulo is bit-serial,
// one dividend bit per cycle), then walks the bucket chain; an unlink then relinks it.
// after reset and after every cfg beat a clearing pass over all MAX_EDGES entries resets
// bucket heads and chain links; cfg is taken then and when idle, an item only when idle.
// a finished result sits in the output register while the next item is accepted.
module degree_preserving_edge_swap_core
  import dpes_pkg::*;
  #(
    parameter int MAX_EDGES    = 4096,
    parameter int NODE_ID_BITS = 32
  )
  (
    input  logic        clk,
    input  logic        rst,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // first_index, second_index, node_a, node_b
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // edge_low, edge_high
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
  );

  localparam int IW  = $clog2(MAX_EDGES);
  localparam int LW  = IW + 1;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int NB  = NODE_ID_BITS;
  localparam int EW  = 2 * NB;
  localparam int PLW = NB + 14;
  localparam int PHW = NB + 10;
  localparam int HW  = NB + 15;
  localparam int BCW = $clog2(HW);
  localparam logic [LW-1:0] NO_ENTRY  = LW'(MAX_EDGES);
  localparam logic [CW-1:0] CNT_RESET = CW'((MAX_EDGES < 4096) ? MAX_EDGES : 4096);

  typedef enum logic [14:0] {
    S_CLEAR   = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_GET_K   = 15'b000000000000100,
    S_GET_L   = 15'b000000000001000,
    S_MUL     = 15'b000000000010000,
    S_SUM     = 15'b000000000100000,
    S_MOD     = 15'b000000001000000,
    S_HEAD_RD = 15'b000000010000000,
    S_HEAD    = 15'b000000100000000,
    S_WALK_RD = 15'b000001000000000,
    S_WALK    = 15'b000010000000000,
    S_UNL_TGT = 15'b000100000000000,
    S_UNL_FIX = 15'b001000000000000,
    S_UNL_CLR = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t state;
  job_t   job;

  logic [CW-1:0]  cnt;
  logic [IW-1:0]  clr_addr;
  logic [1:0]     op;
  logic [11:0]    k;
  logic [11:0]    l;
  logic [EW-1:0]  load_edge;
  logic [EW-1:0]  old_k;
  logic [EW-1:0]  old_l;
  logic [EW-1:0]  new_k;
  logic [EW-1:0]  new_l;
  logic           wr_k;
  logic [PLW-1:0] prod_lo;
  logic [PHW-1:0] prod_hi;
  logic [HW-1:0]  dividend;
  logic [CW-1:0]  rem;
  logic [BCW-1:0] bit_cnt;
  logic [IW-1:0]  cur;
  logic           prev_head;
  logic [1:0]     res_status;
  logic [NB-1:0]  res_lo;
  logic [NB-1:0]  res_hi;

  // memory ports
  logic           edge_we;
  logic [IW-1:0]  edge_wa;
  logic [EW-1:0]  edge_wd;
  logic [IW-1:0]  edge_ra;
  logic [EW-1:0]  edge_rd;
  logic           head_we;
  logic [IW-1:0]  head_wa;
  logic [LW-1:0]  head_wd;
  logic [IW-1:0]  head_ra;
  logic [LW-1:0]  head_rd;
  logic           link_we;
  logic [IW-1:0]  link_wa;
  logic [LW:0]    link_wd;
  logic [IW-1:0]  link_ra;
  logic [LW:0]    link_rd;

  // working values
  logic [EW-1:0]  job_edge;
  logic [IW-1:0]  tgt;
  logic [IW-1:0]  k_idx;
  logic [IW-1:0]  l_idx;
  logic [IW-1:0]  in_k_idx;
  logic [IW-1:0]  h;
  logic [LW-1:0]  nl;
  logic [CW:0]    rem_sh;
  logic [CW-1:0]  rem_next;
  logic           k_bad;
  logic           l_bad;
  logic           range_bad;
  logic [EW-1:0]  e1;
  logic [EW-1:0]  e2;
  logic           job_last;
  job_t           job_next;
  logic           is_con;
  logic           is_unl;
  logic           is_lnk;

  function automatic logic [EW-1:0] pack_edge(input logic [NB-1:0] a, input logic [NB-1:0] b);
    pack_edge = (a > b) ? {a, b} : {b, a};
  endfunction

  dpes_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(edge_wd),
    .rd_addr(edge_ra), .rd_data(edge_rd)
  );

  dpes_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_head_ram (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_addr(head_ra), .rd_data(head_rd)
  );

  // chain link with written flag on top
  dpes_ram #(.WIDTH(LW + 1), .DEPTH(MAX_EDGES)) u_link_ram (
    .clk(clk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
    .rd_addr(link_ra), .rd_data(link_rd)
  );

  // a register write wins over an input beat in the same cycle
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);

  assign in_k_idx = IW'(s_tdata[11:0]);
  assign k_idx    = IW'(k);
  assign l_idx    = IW'(l);
  assign h        = rem[IW-1:0];
  assign nl       = link_rd[LW-1:0];
  assign k_bad    = 32'(k) >= 32'(cnt);
  assign l_bad    = 32'(l) >= 32'(cnt);

  // only the indices an operation uses are range checked
  assign range_bad = (op == OP_SWAP) ? (k_bad || l_bad) :
                     (((op == OP_LOAD) || (op == OP_READ)) && k_bad);

  // swapped edges from the two old edges
  always_comb begin
    if (k < l) begin
      e1 = pack_edge(old_k[NB-1:0], edge_rd[NB-1:0]);
      e2 = pack_edge(old_k[EW-1:NB], edge_rd[EW-1:NB]);
    end else begin
      e1 = pack_edge(old_k[NB-1:0], edge_rd[EW-1:NB]);
      e2 = pack_edge(edge_rd[NB-1:0], old_k[EW-1:NB]);
    end
  end

  // restoring modulo step
  assign rem_sh   = {rem, dividend[HW-1]};
  assign rem_next = (rem_sh >= {1'b0, cnt}) ? CW'(rem_sh - {1'b0, cnt}) : CW'(rem_sh);

  // job decode
  always_comb begin
    is_con   = (job == JOB_CON_1) || (job == JOB_CON_2);
    is_unl   = (job == JOB_UNL_K) || (job == JOB_UNL_L);
    is_lnk   = (job == JOB_LNK_K) || (job == JOB_LNK_L);
    tgt      = ((job == JOB_UNL_L) || (job == JOB_LNK_L)) ? l_idx : k_idx;
    job_last = 1'b0;
    job_next = job;
    job_edge = new_k;
    unique case (job)
      JOB_CON_1: begin
        job_edge = new_k;
        job_next = JOB_CON_2;
      end
      JOB_CON_2: begin
        job_edge = new_l;
        job_next = JOB_UNL_K;
      end
      JOB_UNL_K: begin
        job_edge = old_k;
        job_next = (op == OP_LOAD) ? JOB_LNK_K : JOB_UNL_L;
      end
      JOB_UNL_L: begin
        job_edge = old_l;
        job_next = JOB_LNK_K;
      end
      JOB_LNK_K: begin
        job_edge = new_k;
        job_next = JOB_LNK_L;
        job_last = (op == OP_LOAD);
      end
      JOB_LNK_L: begin
        job_edge = new_l;
        job_last = 1'b1;
      end
      default: begin
        job_edge = new_k;
      end
    endcase
  end

  // memory addresses and writes
  always_comb begin
    edge_we = 1'b0;
    edge_wa = k_idx;
    edge_wd = new_k;
    edge_ra = cur;
    head_we = 1'b0;
    head_wa = h;
    head_wd = NO_ENTRY;
    head_ra = h;
    link_we = 1'b0;
    link_wa = tgt;
    link_wd = {1'b1, NO_ENTRY};
    link_ra = cur;
    unique case (state)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_addr;
        link_we = 1'b1;
        link_wa = clr_addr;
        link_wd = {1'b0, NO_ENTRY};
      end
      S_IDLE: begin
        edge_ra = in_k_idx;
        link_ra = in_k_idx;
      end
      S_GET_K: begin
        edge_ra = l_idx;
        link_ra = l_idx;
      end
      S_MUL: begin
        edge_we = is_lnk;
        edge_wa = tgt;
        edge_wd = job_edge;
      end
      S_HEAD_RD: begin
        link_we = is_lnk;
      end
      S_HEAD: begin
        head_we = is_lnk && (head_rd == NO_ENTRY);
        head_wd = LW'(tgt);
      end
      S_WALK: begin
        link_we = is_lnk && (nl == NO_ENTRY);
        link_wa = cur;
        link_wd = {1'b1, LW'(tgt)};
      end
      S_UNL_TGT: begin
        link_ra = tgt;
      end
      S_UNL_FIX: begin
        head_we = prev_head;
        head_wd = nl;
        link_we = !prev_head;
        link_wa = cur;
        link_wd = {1'b1, nl};
      end
      S_UNL_CLR: begin
        link_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cnt      <= CNT_RESET;
      job      <= JOB_CON_1;
      m_tvalid <= 1'b0;
    end else begin
      // result beat leaves unless a new one takes its place
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        // new modulus: clear the index again
        if (cfg_data == '0) begin
          cnt <= CW'(1);
        end else if (32'(cfg_data) > 32'(MAX_EDGES)) begin
          cnt <= CW'(MAX_EDGES);
        end else begin
          cnt <= CW'(cfg_data);
        end
        clr_addr <= '0;
        state    <= S_CLEAR;
      end else begin
        unique case (state)
          S_CLEAR: begin
            clr_addr <= clr_addr + 1'b1;
            if (clr_addr == IW'(MAX_EDGES - 1)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_tvalid) begin
              op        <= s_tuser;
              k         <= s_tdata[11:0];
              l         <= s_tdata[23:12];
              load_edge <= pack_edge(s_tdata[NB+23:24], s_tdata[NB+55:56]);
              state     <= S_GET_K;
            end
          end
          S_GET_K: begin
            old_k      <= edge_rd;
            wr_k       <= link_rd[LW];
            new_k      <= load_edge;
            res_status <= range_bad ? ST_RANGE : ST_DONE;
            if ((op == OP_READ) && !range_bad && link_rd[LW]) begin
              res_lo <= edge_rd[NB-1:0];
              res_hi <= edge_rd[EW-1:NB];
            end else begin
              res_lo <= '0;
              res_hi <= '0;
            end
            if (!range_bad && (op == OP_LOAD)) begin
              job   <= link_rd[LW] ? JOB_UNL_K : JOB_LNK_K;
              state <= S_MUL;
            end else if (!range_bad && (op == OP_SWAP)) begin
              state <= S_GET_L;
            end else begin
              state <= S_DONE;
            end
          end
          S_GET_L: begin
            old_l <= edge_rd;
            new_k <= e1;
            new_l <= e2;
            if (!wr_k || !link_rd[LW] || (e1[NB-1:0] == e1[EW-1:NB]) ||
                (e2[NB-1:0] == e2[EW-1:NB])) begin
              res_status <= ST_REJECTED;
              state      <= S_DONE;
            end else begin
              job   <= JOB_CON_1;
              state <= S_MUL;
            end
          end
          // hash: products, sum, then one modulo bit per cycle
          S_MUL: begin
            prod_lo <= PLW'(job_edge[NB-1:0]) * PLW'(HASH_MUL_LO);
            prod_hi <= PHW'(job_edge[EW-1:NB]) * PHW'(HASH_MUL_HI);
            state   <= S_SUM;
          end
          S_SUM: begin
            dividend <= HW'(prod_lo) + HW'(prod_hi);
            rem      <= '0;
            bit_cnt  <= BCW'(HW - 1);
            state    <= S_MOD;
          end
          S_MOD: begin
            rem      <= rem_next;
            dividend <= dividend << 1;
            bit_cnt  <= bit_cnt - 1'b1;
            if (bit_cnt == '0) begin
              state <= S_HEAD_RD;
            end
          end
          S_HEAD_RD: begin
            state <= S_HEAD;
          end
          S_HEAD: begin
            cur <= head_rd[IW-1:0];
            if (is_unl && (head_rd == LW'(tgt))) begin
              prev_head <= 1'b1;
              state     <= S_UNL_TGT;
            end else if (head_rd == NO_ENTRY) begin
              if (is_unl) begin
                state <= S_UNL_CLR;
              end else if (job_last) begin
                res_status <= (op == OP_LOAD) ? ST_DONE : ST_APPLIED;
                state      <= S_DONE;
              end else begin
                job   <= job_next;
                state <= S_MUL;
              end
            end else begin
              state <= S_WALK_RD;
            end
          end
          S_WALK_RD: begin
            state <= S_WALK;
          end
          // cur keeps the predecessor when the target is found
          S_WALK: begin
            if (is_con && (edge_rd == job_edge)) begin
              res_status <= ST_REJECTED;
              state      <= S_DONE;
            end else if (is_unl && (nl == LW'(tgt))) begin
              prev_head <= 1'b0;
              state     <= S_UNL_TGT;
            end else if (nl == NO_ENTRY) begin
              if (is_unl) begin
                state <= S_UNL_CLR;
              end else if (job_last) begin
                res_status <= (op == OP_LOAD) ? ST_DONE : ST_APPLIED;
                state      <= S_DONE;
              end else begin
                job   <= job_next;
                state <= S_MUL;
              end
            end else begin
              cur   <= nl[IW-1:0];
              state <= S_WALK_RD;
            end
          end
          S_UNL_TGT: begin
            state <= S_UNL_FIX;
          end
          S_UNL_FIX: begin
            state <= S_UNL_CLR;
          end
          S_UNL_CLR: begin
            job   <= job_next;
            state <= S_MUL;
          end
          S_DONE: begin
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              m_tuser  <= res_status;
              m_tdata  <= {32'(res_hi), 32'(res_lo)};
              state    <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/dpes_ram.sv */
module dpes_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
  )
  (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/dpes_checker.sv */
module dpes_checker
  import dpes_pkg::*;
  (
    input logic        clk,
    input logic        rst,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
  );

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // only a completion with done status (load or read) may carry endpoints
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_DONE) |-> m_tdata == 64'd0)
    else $error("endpoints on a swap or range status");

  // one item at a time: busy right after an accepted beat
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted back to back");

  // a register write starts the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("input ready during clearing pass");

endmodule

bind degree_preserving_edge_swap_core dpes_checker u_dpes_checker (.*);
